// ===== rtl/core/vqtk_pkg.sv =====
// ----------------------------------------------------------------------------
// vqtk_pkg: shared types and constants of the Tokhura-distance VQ search
// Widths, command encoding and the fixed cepstral weight table.
// ----------------------------------------------------------------------------
package vqtk_pkg;

	// Geometry of the codebook and of one element
	localparam int CODEWORDS   = 32;
	localparam int ORDER       = 12;
	localparam int VALUE_WIDTH = 16;

	// Port field widths
	localparam int CODEWORD_W = 5;
	localparam int COEF_W     = 4;
	localparam int CFG_W      = 6;
	localparam int DIST_W     = 41;
	localparam int INDEX_W    = 5;

	// Derived widths
	localparam int DEPTH    = CODEWORDS * ORDER;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int WORD_W   = (CODEWORDS > 1) ? $clog2(CODEWORDS) : 1;
	localparam int CNT_W    = $clog2(CODEWORDS + 1);
	localparam int POS_W    = $clog2(ORDER);
	localparam int DIFF_W   = VALUE_WIDTH + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int WEIGHT_W = 6;
	localparam int TERM_W   = SQ_W + WEIGHT_W;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// Input kind codes
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_QUERY  = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [ADDR_W-1:0]       addr;
		logic [POS_W-1:0]        pos;
		logic [VALUE_WIDTH-1:0]  value;
	} cmd_t;

	// Tokhura cepstral weights
	function automatic logic [WEIGHT_W-1:0] tk_weight(input logic [POS_W-1:0] j);
		logic [WEIGHT_W-1:0] w;
		unique case (j)
			4'd0:    w = 6'd1;
			4'd1:    w = 6'd3;
			4'd2:    w = 6'd7;
			4'd3:    w = 6'd13;
			4'd4:    w = 6'd19;
			4'd5:    w = 6'd22;
			4'd6:    w = 6'd25;
			4'd7:    w = 6'd33;
			4'd8:    w = 6'd42;
			4'd9:    w = 6'd50;
			4'd10:   w = 6'd56;
			4'd11:   w = 6'd61;
			default: w = 6'd0;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/vqtk_ram.sv =====
// ----------------------------------------------------------------------------
// vqtk_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vqtk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/vqtk_front.sv =====
// ----------------------------------------------------------------------------
// vqtk_front: input classification
// Sort input items into loads, query elements and search starts; drop
// items with an element position or word index out of range.
// ----------------------------------------------------------------------------
module vqtk_front (
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic [vqtk_pkg::CODEWORD_W-1:0]    codeword,
	input  logic [vqtk_pkg::COEF_W-1:0]        coef_index,
	input  logic signed [vqtk_pkg::VALUE_WIDTH-1:0] value,
	input  logic                               q_full,
	output logic                               q_push,
	output vqtk_pkg::cmd_t                     q_cmd
);
	import vqtk_pkg::*;

	logic pos_ok;
	logic word_ok;
	logic keep;

	assign pos_ok  = 32'(coef_index) < 32'(ORDER);
	assign word_ok = 32'(codeword) < 32'(CODEWORDS);
	assign keep    = pos_ok && ((kind == KIND_QUERY) || word_ok);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full && keep;

	always_comb begin
		q_cmd.addr  = ADDR_W'(ADDR_W'(codeword) * ADDR_W'(ORDER) + ADDR_W'(coef_index));
		q_cmd.pos   = POS_W'(coef_index);
		q_cmd.value = value;
		if (kind == KIND_LOAD) begin
			q_cmd.op = OP_LOAD;
		end else if (32'(coef_index) == 32'(ORDER - 1)) begin
			q_cmd.op = OP_SEARCH;
		end else begin
			q_cmd.op = OP_QUERY;
		end
	end

endmodule

// ===== rtl/core/vqtk_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// vqtk_cmd_queue: short command FIFO
// Decouple the classifying front from the executing back.
// ----------------------------------------------------------------------------
module vqtk_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vqtk_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output vqtk_pkg::cmd_t head_cmd
);
	import vqtk_pkg::*;

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;

	function automatic logic [CMDQ_PTR_W-1:0] next_ptr(input logic [CMDQ_PTR_W-1:0] p);
		return (32'(p) == CMDQ_DEPTH - 1) ? '0 : CMDQ_PTR_W'(p + 1'b1);
	endfunction

	assign full       = 32'(count_q) == CMDQ_DEPTH;
	assign head_valid = count_q != '0;
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= CMDQ_CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CMDQ_CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

// ===== rtl/core/vqtk_back.sv =====
// ----------------------------------------------------------------------------
// vqtk_back: command execution and distance search
// Write codebook and query elements; on a search, stream the codebook
// through a four-stage multiply-accumulate pipeline and keep the best word.
// ----------------------------------------------------------------------------
module vqtk_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  vqtk_pkg::cmd_t                  cmd,
	output logic                            cmd_pop,
	input  logic [vqtk_pkg::CFG_W-1:0]      words_cfg,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vqtk_pkg::INDEX_W-1:0]    best_index,
	output logic [vqtk_pkg::DIST_W-1:0]     best_distance
);
	import vqtk_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;

	// Codebook and query storage
	logic                          ram_we;
	logic [ADDR_W-1:0]             raddr_q;
	logic [VALUE_WIDTH-1:0]        ram_rdata;
	logic signed [VALUE_WIDTH-1:0] query_q [ORDER];

	// Search counters
	logic [POS_W-1:0]  j_q;
	logic [WORD_W-1:0] w_q;
	logic [WORD_W-1:0] last_w_q;
	logic [CNT_W-1:0]  used_eff;
	logic              issue;
	logic              start_search;

	// Pipeline
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [POS_W-1:0]  j_s1, j_s2, j_s3, j_s4;
	logic [WORD_W-1:0] w_s1, w_s2, w_s3, w_s4;
	logic              lastw_s1, lastw_s2, lastw_s3, lastw_s4;
	logic [DIFF_W-1:0] abs_s2;
	logic [SQ_W-1:0]   sq_s3;
	logic [TERM_W-1:0] term_s4;

	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        diff_abs;

	// Accumulation and best tracking
	logic [DIST_W-1:0] acc_q;
	logic              sat_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [WORD_W-1:0] best_w_q;
	logic [DIST_W:0]   sum;
	logic              sat_now;
	logic [DIST_W-1:0] word_dist;
	logic              word_end;
	logic              better;
	logic              done;

	logic                 out_valid_q;
	logic [INDEX_W-1:0]   out_index_q;
	logic [DIST_W-1:0]    out_dist_q;

	// Command issue: a search waits until the previous result is taken
	assign start_search = (state_q == ST_IDLE) && cmd_valid && (cmd.op == OP_SEARCH)
		&& !out_valid_q;
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid
		&& ((cmd.op != OP_SEARCH) || !out_valid_q);
	assign ram_we  = cmd_pop && (cmd.op == OP_LOAD);
	assign issue   = state_q == ST_RUN;

	always_comb begin
		if (words_cfg == '0) begin
			used_eff = CNT_W'(1);
		end else if (32'(words_cfg) > 32'(CODEWORDS)) begin
			used_eff = CNT_W'(CODEWORDS);
		end else begin
			used_eff = CNT_W'(words_cfg);
		end
	end

	vqtk_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(DEPTH)
	) u_codebook (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cmd.addr),
		.wdata(cmd.value),
		.raddr(raddr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.op != OP_LOAD)) begin
			query_q[cmd.pos] <= cmd.value;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			raddr_q  <= '0;
			j_q      <= '0;
			w_q      <= '0;
			last_w_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start_search) begin
						state_q  <= ST_RUN;
						raddr_q  <= '0;
						j_q      <= '0;
						w_q      <= '0;
						last_w_q <= WORD_W'(used_eff - 1'b1);
					end
				end
				ST_RUN: begin
					raddr_q <= ADDR_W'(raddr_q + 1'b1);
					if (32'(j_q) == ORDER - 1) begin
						j_q <= '0;
						w_q <= WORD_W'(w_q + 1'b1);
						if (w_q == last_w_q) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						j_q <= POS_W'(j_q + 1'b1);
					end
				end
				ST_DRAIN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Difference and magnitude against the registered codebook read
	assign diff     = $signed({query_q[j_s1][VALUE_WIDTH-1], query_q[j_s1]})
		- $signed({ram_rdata[VALUE_WIDTH-1], ram_rdata});
	assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(~diff + 1'b1) : DIFF_W'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		j_s1     <= j_q;
		w_s1     <= w_q;
		lastw_s1 <= w_q == last_w_q;
		j_s2     <= j_s1;
		w_s2     <= w_s1;
		lastw_s2 <= lastw_s1;
		abs_s2   <= diff_abs;
		j_s3     <= j_s2;
		w_s3     <= w_s2;
		lastw_s3 <= lastw_s2;
		sq_s3    <= SQ_W'(abs_s2) * SQ_W'(abs_s2);
		j_s4     <= j_s3;
		w_s4     <= w_s3;
		lastw_s4 <= lastw_s3;
		term_s4  <= TERM_W'(sq_s3) * TERM_W'(tk_weight(j_s3));
	end

	// Accumulate one weighted term per cycle; saturate on overflow
	always_comb begin
		if (j_s4 == '0) begin
			sum     = (DIST_W + 1)'(term_s4);
			sat_now = sum[DIST_W];
		end else begin
			sum     = (DIST_W + 1)'(acc_q) + (DIST_W + 1)'(term_s4);
			sat_now = sat_q || sum[DIST_W];
		end
		word_dist = sat_now ? '1 : sum[DIST_W-1:0];
		word_end  = v_s4 && (32'(j_s4) == ORDER - 1);
		better    = (w_s4 == '0) || (word_dist < best_dist_q);
		done      = word_end && lastw_s4;
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			acc_q <= sum[DIST_W-1:0];
			sat_q <= sat_now;
		end
		if (word_end && better) begin
			best_dist_q <= word_dist;
			best_w_q    <= w_s4;
		end
		if (done) begin
			out_index_q <= better ? INDEX_W'(w_s4) : INDEX_W'(best_w_q);
			out_dist_q  <= better ? word_dist : best_dist_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign best_index    = out_index_q;
	assign best_distance = out_dist_q;

`ifndef SYNTH
	// A finished search never lands on a result that is still pending
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_valid_q)
		else $error("search result overwrote a pending result");

	// Commands are taken only between searches
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == ST_IDLE)
		else $error("command popped during a search");

	// The pipeline is empty whenever the sequencer is idle
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !v_s1 && !v_s2 && !v_s3 && !v_s4)
		else $error("pipeline busy while idle");

	// Every search ends with exactly one result
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == ST_IDLE && out_valid_q)
		else $error("search end not followed by a result");
`endif

endmodule

// ===== rtl/core/vq_nearest_codeword_tokhura_unit.sv =====
// ----------------------------------------------------------------------------
// vq_nearest_codeword_tokhura_unit: vector-quantizer nearest-codeword search
// Tokhura-weighted cepstral distance over a 32 x 12 codebook.
// ----------------------------------------------------------------------------
// Load items (kind 0) write one signed Q8.8 element into the codebook at
// word codeword, element coef_index; query items (kind 1) fill the query
// vector, and the query item at element 11 starts a search over words 0 to
// codewords_used-1 (0 counts as 1, above 32 as 32). The result is the
// lowest-indexed word with the smallest sum of w[j]*(q[j]-c[j])^2, with the
// weights 1..61, and that undivided Q16.16 distance. Items with element
// position 12 or higher are accepted and dropped. Loads and query elements
// go through a two-entry command queue. A search reads the codebook RAM
// one element per cycle and occupies the back end until its last word is
// accumulated; the queue keeps accepting up to two further items meanwhile.
// A result stays on the output register until taken, and a following
// search waits for it. The codebook has no clearing pass: read only words
// that were written. Write codewords_used only while the block is idle.
// ----------------------------------------------------------------------------
module vq_nearest_codeword_tokhura_unit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Input items
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     kind,
	input  logic [vqtk_pkg::CODEWORD_W-1:0]          codeword,
	input  logic [vqtk_pkg::COEF_W-1:0]              coef_index,
	input  logic signed [vqtk_pkg::VALUE_WIDTH-1:0]  value,
	// Results
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [vqtk_pkg::INDEX_W-1:0]             best_index,
	output logic [vqtk_pkg::DIST_W-1:0]              best_distance,
	// Configuration: codewords_used
	input  logic                                     cfg_we,
	input  logic [vqtk_pkg::CFG_W-1:0]               cfg_wdata
);
	import vqtk_pkg::*;

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_head_valid;
	cmd_t             q_push_cmd;
	cmd_t             q_head_cmd;
	logic [CFG_W-1:0] words_cfg_q;

	// Hold the search count; reset to the full codebook
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_cfg_q <= CFG_W'(32);
		end else if (cfg_we) begin
			words_cfg_q <= cfg_wdata;
		end
	end

	// Front: classify and drop out-of-range items
	vqtk_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.codeword  (codeword),
		.coef_index(coef_index),
		.value     (value),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_push_cmd)
	);

	// Queue: let the front keep taking transfers while a search runs
	vqtk_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head_cmd  (q_head_cmd)
	);

	// Back: execute writes and searches, own the result register
	vqtk_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_head_valid),
		.cmd          (q_head_cmd),
		.cmd_pop      (q_pop),
		.words_cfg    (words_cfg_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.best_index   (best_index),
		.best_distance(best_distance)
	);

endmodule

// ===== tb/tb_vq_nearest_codeword_tokhura_unit.sv =====
// ----------------------------------------------------------------------------
// tb_vq_nearest_codeword_tokhura_unit: self-checking bench for the VQ search
// Drives codebook loads and query elements, predicts each nearest-codeword
// result with a local Tokhura distance model and compares every transfer.
// ----------------------------------------------------------------------------
module tb_vq_nearest_codeword_tokhura_unit;
	import vqtk_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	// Room for a few queued loads after the last result
	localparam int SETTLE_CYCLES = 24;
	// One full search over every word plus margin
	localparam int TAIL_CYCLES   = 12 * CODEWORDS + 40;
	localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 64'd1;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [DIST_W-1:0]  distance;
	} nearest_t;

	// DUT inputs, all known from time zero
	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          in_valid   = 1'b0;
	logic                          kind       = KIND_LOAD;
	logic [CODEWORD_W-1:0]         codeword   = '0;
	logic [COEF_W-1:0]             coef_index = '0;
	logic signed [VALUE_WIDTH-1:0] value      = '0;
	logic                          out_ready  = 1'b0;
	logic                          cfg_we     = 1'b0;
	logic [CFG_W-1:0]              cfg_wdata  = '0;

	// DUT outputs
	logic                          in_ready;
	logic                          out_valid;
	logic [INDEX_W-1:0]            best_index;
	logic [DIST_W-1:0]             best_distance;

	// Predictor state: codebook, query vector and the search-count register
	logic signed [VALUE_WIDTH-1:0] codebook_model [CODEWORDS*ORDER];
	logic signed [VALUE_WIDTH-1:0] query_model [ORDER];
	int unsigned                   words_searched_cfg;
	longint unsigned               cep_weight [ORDER] =
		'{1, 3, 7, 13, 19, 22, 25, 33, 42, 50, 56, 61};

	// Nearest-codeword results still owed by the block, oldest first
	nearest_t nearest_q [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int stall_left     = 0;
	bit tx_idle_on     = 1'b0;
	bit rx_idle_on     = 1'b0;

	vq_nearest_codeword_tokhura_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.codeword      (codeword),
		.coef_index    (coef_index),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.best_index    (best_index),
		.best_distance (best_distance),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Watchdog: stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Effective word count: zero counts as one, anything above the
	// codebook size is clamped to it.
	function automatic int searched_words();
		int n;
		n = words_searched_cfg;
		if (n == 0)
			n = 1;
		if (n > CODEWORDS)
			n = CODEWORDS;
		return n;
	endfunction

	// Weighted squared cepstral distance between the query and word w,
	// saturated to the result width.
	function automatic longint unsigned tokhura_distance(input int w);
		longint unsigned acc;
		longint unsigned mag;
		longint          diff;
		bit              sat;
		int              j;
		acc = 0;
		sat = 1'b0;
		for (j = 0; j < ORDER; j++) begin
			diff = longint'(query_model[j]) - longint'(codebook_model[w*ORDER + j]);
			mag  = (diff < 0) ? -diff : diff;
			acc += mag * mag * cep_weight[j];
			if (acc > DIST_MAX)
				sat = 1'b1;
		end
		return sat ? DIST_MAX : acc;
	endfunction

	// Apply one accepted item; a query at the last element queues the
	// nearest word and its distance.
	function automatic void predict_item(input logic k, input logic [CODEWORD_W-1:0] cw,
			input logic [COEF_W-1:0] ci, input logic signed [VALUE_WIDTH-1:0] v);
		int              n;
		int              w;
		int              best_w;
		longint unsigned best_d;
		longint unsigned d;
		nearest_t        r;
		// Element positions past the vector end are dropped
		if (ci >= ORDER)
			return;
		if (k == KIND_LOAD) begin
			codebook_model[cw*ORDER + ci] = v;
			return;
		end
		query_model[ci] = v;
		if (ci != ORDER - 1)
			return;
		n      = searched_words();
		best_w = 0;
		best_d = tokhura_distance(0);
		// Strict less-than keeps the lowest index on ties
		for (w = 1; w < n; w++) begin
			d = tokhura_distance(w);
			if (d < best_d) begin
				best_d = d;
				best_w = w;
			end
		end
		r.index    = INDEX_W'(best_w);
		r.distance = DIST_W'(best_d);
		nearest_q  = {nearest_q, r};
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one item and hold it until the transfer; predict on acceptance.
	task automatic send_item(input logic k, input logic [CODEWORD_W-1:0] cw,
			input logic [COEF_W-1:0] ci, input logic signed [VALUE_WIDTH-1:0] v);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		codeword   <= cw;
		coef_index <= ci;
		value      <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(k, cw, ci, v);
	endtask

	// Item at an out-of-range element position: accepted and dropped
	task automatic send_noise();
		send_item(1'($urandom), CODEWORD_W'($urandom),
			COEF_W'($urandom_range(ORDER, (1 << COEF_W) - 1)), VALUE_WIDTH'($urandom));
	endtask

	// Drop valid, wait for every owed result, then let the back end settle
	task automatic drain_results(input int extra);
		in_valid <= 1'b0;
		while (nearest_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Write the search-count register once the block is idle
	task automatic set_codewords_used(input logic [CFG_W-1:0] n);
		drain_results(SETTLE_CYCLES);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		words_searched_cfg = 32'(n);
	endtask

	// Query element drawn near a codeword, on it, or anywhere in range
	function automatic logic signed [VALUE_WIDTH-1:0] query_value(input int w, input int j);
		unique case ($urandom_range(0, 3))
			0:       return VALUE_WIDTH'($urandom);
			1:       return codebook_model[w*ORDER + j];
			default: return VALUE_WIDTH'(codebook_model[w*ORDER + j]
				+ $urandom_range(0, 64) - 32);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result side: check each transfer, stall in random bursts
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		nearest_t want;
		if (arst_n && out_valid && out_ready) begin
			if (nearest_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected: index %0d distance %0d",
					$time, best_index, best_distance);
			end else begin
				want = nearest_q.pop_front();
				if (best_index !== want.index) begin
					mismatch_count++;
					$display("%0t: best_index expected %0d actual %0d",
						$time, want.index, best_index);
				end
				if (best_distance !== want.distance) begin
					mismatch_count++;
					$display("%0t: best_distance expected %0d actual %0d",
						$time, want.distance, best_distance);
				end
			end
		end
		// Stall in bursts of random length
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// One-word search (count zero counts as one) at full-scale opposite
	// values, dropped items at bad positions, and a re-search triggered by
	// the last element alone.
	task automatic test_single_word_extremes();
		int j;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		set_codewords_used('0);
		for (j = 0; j < ORDER; j++)
			send_item(KIND_LOAD, '0, COEF_W'(j), (j % 2) ? 16'sh8000 : 16'sh7FFF);
		send_item(KIND_LOAD, 5'd31, 4'd15, 16'sh7FFF);
		send_item(KIND_QUERY, 5'd31, 4'd12, 16'sh8000);
		// Largest distance the weights allow
		for (j = 0; j < ORDER; j++)
			send_item(KIND_QUERY, CODEWORD_W'($urandom), COEF_W'(j),
				(j % 2) ? 16'sh7FFF : 16'sh8000);
		// Match the last element only; rest of the query is kept
		send_item(KIND_QUERY, '0, COEF_W'(ORDER - 1), 16'sh8000);
		drain_results(SETTLE_CYCLES);
	endtask

	// Write every codebook element in a rotated order, then search the
	// whole book with an over-range count.
	task automatic test_codebook_fill();
		int w;
		int k;
		int rot;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (w = 0; w < CODEWORDS; w++) begin
			rot = $urandom_range(0, ORDER - 1);
			for (k = 0; k < ORDER; k++) begin
				if ($urandom_range(0, 31) == 0)
					send_noise();
				send_item(KIND_LOAD, CODEWORD_W'(w), COEF_W'((k + rot) % ORDER),
					VALUE_WIDTH'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 511) - 256 : $urandom));
			end
		end
		set_codewords_used(6'd63);
		for (k = 0; k < ORDER; k++)
			send_item(KIND_QUERY, CODEWORD_W'($urandom), COEF_W'(k), VALUE_WIDTH'($urandom));
		drain_results(SETTLE_CYCLES);
	endtask

	// Two identical words must resolve to the lower index; a query equal
	// to the last word gives a zero distance.
	task automatic test_tie_and_exact_hit();
		int j;
		set_codewords_used(6'd2);
		for (j = 0; j < ORDER; j++)
			send_item(KIND_LOAD, 5'd1, COEF_W'(j), codebook_model[j]);
		send_item(KIND_QUERY, CODEWORD_W'($urandom), COEF_W'(ORDER - 1),
			VALUE_WIDTH'($urandom));
		set_codewords_used(6'd32);
		for (j = 0; j < ORDER; j++)
			send_item(KIND_QUERY, CODEWORD_W'($urandom), COEF_W'(j),
				codebook_model[(CODEWORDS - 1)*ORDER + j]);
		drain_results(SETTLE_CYCLES);
	endtask

	// Mostly complete query vectors with random content, plus codebook
	// updates, partial query updates and dropped items.
	task automatic test_random_traffic(input logic [CFG_W-1:0] n_cfg, input int n_items,
			input bit tx_on, input bit rx_on);
		int done;
		int r;
		int j;
		int cnt;
		int base_w;
		set_codewords_used(n_cfg);
		tx_idle_on = tx_on;
		rx_idle_on = rx_on;
		done = 0;
		while (done < n_items) begin
			r      = $urandom_range(0, 99);
			base_w = $urandom_range(0, searched_words() - 1);
			if (r < 55) begin
				for (j = 0; j < ORDER; j++) begin
					if ($urandom_range(0, 15) == 0)
						send_noise();
					send_item(KIND_QUERY, CODEWORD_W'($urandom), COEF_W'(j),
						query_value(base_w, j));
				end
				done += ORDER;
			end else if (r < 70) begin
				cnt = $urandom_range(1, 3);
				repeat (cnt)
					send_item(KIND_LOAD, CODEWORD_W'($urandom),
						COEF_W'($urandom_range(0, ORDER - 1)), VALUE_WIDTH'($urandom));
				done += cnt;
			end else if (r < 88) begin
				cnt = $urandom_range(1, 3);
				repeat (cnt) begin
					j = $urandom_range(0, ORDER - 2);
					send_item(KIND_QUERY, CODEWORD_W'($urandom), COEF_W'(j),
						query_value(base_w, j));
				end
				send_item(KIND_QUERY, CODEWORD_W'($urandom), COEF_W'(ORDER - 1),
					query_value(base_w, ORDER - 1));
				done += cnt + 1;
			end else begin
				send_noise();
			end
		end
		drain_results(SETTLE_CYCLES);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin : main_sequence
		int               i;
		int               phase;
		logic [CFG_W-1:0] n_cfg;
		for (i = 0; i < CODEWORDS*ORDER; i++)
			codebook_model[i] = '0;
		for (i = 0; i < ORDER; i++)
			query_model[i] = '0;
		words_searched_cfg = CODEWORDS;

		// Hold reset, then release it on an edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_word_extremes();
		test_codebook_fill();
		test_tie_and_exact_hit();

		// Sweep the search count across its extremes and the values between
		for (phase = 0; phase < 8; phase++) begin
			unique case (phase)
				0:       n_cfg = 6'd1;
				1:       n_cfg = 6'd32;
				2:       n_cfg = 6'd0;
				3:       n_cfg = 6'd63;
				4:       n_cfg = CFG_W'($urandom_range(2, 31));
				5:       n_cfg = CFG_W'($urandom_range(33, 62));
				6:       n_cfg = 6'd32;
				default: n_cfg = CFG_W'($urandom_range(1, 32));
			endcase
			test_random_traffic(n_cfg, 110, phase != 2, phase != 1);
		end

		// Closing stretch at full rate on both sides
		test_random_traffic(6'd17, 130, 1'b0, 1'b0);

		drain_results(TAIL_CYCLES);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/vqtk_pkg.sv
rtl/core/vqtk_ram.sv
rtl/core/vqtk_front.sv
rtl/core/vqtk_cmd_queue.sv
rtl/core/vqtk_back.sv
rtl/core/vq_nearest_codeword_tokhura_unit.sv
tb/tb_vq_nearest_codeword_tokhura_unit.sv
